// ===== src/lhrm_pkg.sv =====
package lhrm_pkg;

  localparam int MaxHeads = 16;
  localparam int HeadIdxW = 4;
  localparam int HeadCntW = 5;
  localparam int LedW = 8;
  localparam logic [LedW-1:0] LedCap = 8'd255;
  localparam int ErrW = 34;
  localparam logic [ErrW-1:0] FrameStartErr = 34'd2560000000;

  // Register indexes of the configuration port.
  localparam logic RegTargetRadius = 1'b0;
  localparam logic RegAcceptLimit = 1'b1;

  // Item codes.
  localparam logic FuncLoad = 1'b0;
  localparam logic FuncMatch = 1'b1;

endpackage

// ===== src/lhrm_sqrt.sv =====
// Bit-serial floor square root of a 34-bit value: one result bit per cycle.
module lhrm_sqrt
  import lhrm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [33:0] radicand,
  output logic        done,
  output logic [16:0] root
);

  logic [33:0] rem;
  logic [33:0] val;
  logic [4:0]  step;
  logic        busy;
  logic [35:0] trial;
  logic [35:0] rem_shift;

  // Bring down two radicand bits and try the next root bit.
  always_comb begin
    rem_shift = {rem, val[33:32]};
    trial = {17'd0, root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem <= '0;
        val <= radicand;
        root <= '0;
        step <= '0;
      end else if (busy) begin
        val <= {val[31:0], 2'b00};
        if (rem_shift >= trial) begin
          rem <= 34'(rem_shift - trial);
          root <= {root[15:0], 1'b1};
        end else begin
          rem <= rem_shift[33:0];
          root <= {root[15:0], 1'b0};
        end
        step <= step + 5'd1;
        if (step == 5'd16) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/led_head_radius_matcher_unit.sv =====
// Head load: taken while idle, back to back. LED match: each stored head is read, its
// differences, squared distance, square root on the shared bit-serial square-root unit,
// deviation and error are formed in turn; an empty table skips to the output state.
// One item at a time; a result waits in an output register until taken, and the next
// item is taken once the unit is back in idle. Synchronous active-high reset restores
// counters, frame best and registers; the head table is never cleared.
module led_head_radius_matcher_unit
  import lhrm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [15:0] point_x,
  input  logic [15:0] point_y,
  input  logic        frame_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  led_number,
  output logic        head_found,
  output logic [3:0]  head_number,
  output logic [33:0] match_error,
  output logic        kept,
  output logic [7:0]  best_led,
  output logic        best_valid,
  output logic        end_of_frame
);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_DIFF, S_SQR, S_ROOT, S_DEV, S_ERR, S_OUT
  } state_t;

  state_t state;
  logic [7:0]  target_radius;
  logic [15:0] accept_limit;
  logic [15:0] head_x [MaxHeads];
  logic [15:0] head_y [MaxHeads];
  logic [HeadCntW-1:0] head_count;
  logic [LedW-1:0] led_count;
  logic [ErrW-1:0] gbest_err;
  logic [LedW-1:0] gbest_idx;
  logic        gbest_seen;
  logic [15:0] px, py, hx, hy;
  logic        fend;
  logic [HeadIdxW-1:0] j;
  logic [15:0] dx, dy;
  logic [33:0] sumsq;
  logic [16:0] dev;
  logic [ErrW-1:0] best_err;
  logic [HeadIdxW-1:0] best_head;
  logic        sq_start, sq_done;
  logic [16:0] root;
  logic [16:0] r16;
  logic [ErrW-1:0] err;
  logic        last_head;
  logic        sq_go;

  lhrm_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .radicand(sumsq),
    .done(sq_done), .root(root)
  );

  assign r16 = {5'd0, target_radius, 4'd0};
  assign err = ErrW'(dev * dev);
  assign last_head = ({1'b0, j} == head_count - HeadCntW'(1));
  assign in_ready = (state == S_IDLE);
  assign sq_start = sq_go;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      target_radius <= 8'd36;
      accept_limit <= 16'd2000;
    end else if (cfg_we) begin
      if (cfg_index == RegTargetRadius) target_radius <= cfg_data[7:0];
      if (cfg_index == RegAcceptLimit) accept_limit <= cfg_data;
    end
  end

  // Head table.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid && func == FuncLoad && !head_count[HeadCntW-1]) begin
      head_x[head_count[HeadIdxW-1:0]] <= point_x;
      head_y[head_count[HeadIdxW-1:0]] <= point_y;
    end
  end

  // Sequencer over stored heads.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      head_count <= '0;
      led_count <= '0;
      gbest_err <= FrameStartErr;
      gbest_idx <= '0;
      gbest_seen <= 1'b0;
      sq_go <= 1'b0;
    end else begin
      sq_go <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (func == FuncLoad) begin
              if (!head_count[HeadCntW-1]) head_count <= head_count + HeadCntW'(1);
            end else begin
              px <= point_x;
              py <= point_y;
              fend <= frame_end;
              j <= '0;
              best_err <= '0;
              best_head <= '0;
              led_number <= led_count;
              state <= (head_count == '0) ? S_OUT : S_READ;
            end
          end
        end
        S_READ: begin
          hx <= head_x[j];
          hy <= head_y[j];
          state <= S_DIFF;
        end
        S_DIFF: begin
          dx <= (px >= hx) ? px - hx : hx - px;
          dy <= (py >= hy) ? py - hy : hy - py;
          state <= S_SQR;
        end
        S_SQR: begin
          sumsq <= 34'(dx * dx) + 34'(dy * dy);
          sq_go <= 1'b1;
          state <= S_ROOT;
        end
        S_ROOT: begin
          if (sq_done) begin
            dev <= (root >= r16) ? root - r16 : r16 - root;
            state <= S_DEV;
          end
        end
        S_DEV: begin
          state <= S_ERR;
        end
        S_ERR: begin
          if (j == '0 || err < best_err) begin
            best_err <= err;
            best_head <= j;
          end
          if (last_head) state <= S_OUT;
          else begin
            j <= j + HeadIdxW'(1);
            state <= S_READ;
          end
        end
        S_OUT: begin
          if (!out_valid) begin
            head_found <= (head_count != '0);
            head_number <= best_head;
            match_error <= best_err;
            kept <= (head_count != '0) && (best_err < {10'd0, accept_limit, 8'd0});
            end_of_frame <= fend;
            if (head_count != '0 && best_err < gbest_err) begin
              best_led <= led_number;
              best_valid <= 1'b1;
            end else begin
              best_led <= gbest_idx;
              best_valid <= gbest_seen;
            end
            if (fend) begin
              head_count <= '0;
              led_count <= '0;
              gbest_err <= FrameStartErr;
              gbest_idx <= '0;
              gbest_seen <= 1'b0;
            end else begin
              if (led_count != LedCap) led_count <= led_count + LedW'(1);
              if (head_count != '0 && best_err < gbest_err) begin
                gbest_err <= best_err;
                gbest_idx <= led_number;
                gbest_seen <= 1'b1;
              end
            end
            out_valid <= 1'b1;
          end else if (out_ready) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_only_in_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_OUT) else $error("result shown outside output state");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_head_cap: assert property (@(posedge clk) disable iff (rst)
    head_count <= HeadCntW'(MaxHeads)) else $error("head count beyond table");
`endif

endmodule
